// File: rtl/core/csd_pkg.sv
// ---------------------------------------------------------------------------
// csd_pkg: shared types and constants of the carrier sequence decoder
// Field widths, status codes and the word structs passed between modules.
// ---------------------------------------------------------------------------
package csd_pkg;

    localparam int NUM_LANES  = 4;
    localparam int WORD_W     = 64;
    localparam int SLOT_W     = 53;
    localparam int EXP_W      = 11;
    localparam int EXP_LSB    = 52;
    localparam int MANT_W     = 52;
    localparam int SHORT_W    = 16;
    localparam int META_W     = 52;
    localparam int ORD_W      = 64;

    localparam logic [EXP_W-1:0] EXP_RESET = 11'd1023;

    // Status codes, in check order
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_EXP   = 3'd1,
        ST_ZERO_RUN  = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    // What one lane finds in one carrier word
    typedef struct packed {
        logic              exp_ok;
        logic [SLOT_W-1:0] slot;
    } t_lane;

    // One decoded result word
    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  id_high_lane;
        logic [WORD_W-1:0]  id_low_lane;
        logic [ORD_W-1:0]   running_ord;
        logic [SHORT_W-1:0] carried_ord;
        logic [SHORT_W-1:0] span_len;
        logic [META_W-1:0]  metadata;
        logic [ORD_W-1:0]   total_count;
        logic               sequence_end;
    } t_result;

endpackage

// File: rtl/core/csd_lane.sv
// ---------------------------------------------------------------------------
// csd_lane: one carrier word lane
// Checks the biased exponent and extracts the 53-bit payload slot.
// ---------------------------------------------------------------------------
module csd_lane
    import csd_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic [EXP_W-1:0]  i_exponent,
    output t_lane             o_lane
);

    // Compare exponent, move sign above the mantissa
    always_comb begin
        o_lane.exp_ok = (i_word[EXP_LSB +: EXP_W] == i_exponent);
        o_lane.slot   = {i_word[WORD_W-1], i_word[MANT_W-1:0]};
    end

endmodule

// File: rtl/core/csd_merge.sv
// ---------------------------------------------------------------------------
// csd_merge: lane merge and ordinal tracking
// Repacks the four slots, runs the ordered checks and holds next ordinal.
// ---------------------------------------------------------------------------
module csd_merge
    import csd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane                i_lanes [NUM_LANES],
    input  logic                 i_accept,
    input  logic                 i_last,
    output t_result              o_result
);

    logic [ORD_W-1:0]   r_next_ordinal;
    logic [ORD_W-1:0]   n_next_ordinal;
    logic               all_ok;
    logic [SHORT_W-1:0] packed_ord;
    logic [SHORT_W-1:0] run;
    logic [SHORT_W-1:0] run_m1;
    logic [SHORT_W-1:0] expected;
    logic [ORD_W:0]     sum;
    logic [ORD_W-1:0]   total;

    // Slot fields of the ordinal word
    assign all_ok     = i_lanes[0].exp_ok && i_lanes[1].exp_ok &&
                        i_lanes[2].exp_ok && i_lanes[3].exp_ok;
    assign packed_ord = i_lanes[3].slot[SHORT_W-1:0];
    assign run        = i_lanes[3].slot[2*SHORT_W-1:SHORT_W];
    assign run_m1     = run - SHORT_W'(1);
    assign expected   = (r_next_ordinal[ORD_W-1:SHORT_W] == '0)
                        ? r_next_ordinal[SHORT_W-1:0] : '0;

    // Two parallel adds: advance and inclusive end of the run
    assign sum   = {1'b0, r_next_ordinal} + {{(ORD_W+1-SHORT_W){1'b0}}, run};
    assign total = r_next_ordinal + {{(ORD_W-SHORT_W){1'b0}}, run_m1};

    // Checks in order, repack, and next ordinal
    always_comb begin
        o_result                 = '0;
        o_result.running_ord     = r_next_ordinal;
        o_result.sequence_end    = i_last;
        n_next_ordinal           = r_next_ordinal;
        if (!all_ok) begin
            o_result.status = ST_BAD_EXP;
        end else begin
            o_result.id_low_lane  = {i_lanes[1].slot[10:0], i_lanes[0].slot};
            o_result.id_high_lane = {i_lanes[2].slot[21:0], i_lanes[1].slot[52:11]};
            o_result.metadata     = {i_lanes[3].slot[52:32], i_lanes[2].slot[52:22]};
            o_result.carried_ord  = packed_ord;
            o_result.span_len     = run;
            priority if (run == '0) begin
                o_result.status = ST_ZERO_RUN;
            end else if (packed_ord != expected) begin
                o_result.status = ST_MISMATCH;
            end else if (sum[ORD_W]) begin
                o_result.status = ST_OVERFLOW;
            end else begin
                o_result.status      = ST_OK;
                o_result.total_count = total;
                n_next_ordinal       = sum[ORD_W-1:0];
            end
        end
        if (i_last) begin
            n_next_ordinal = {{(ORD_W-1){1'b0}}, 1'b1};
        end
    end

    // Advance the ordinal only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ordinal <= {{(ORD_W-1){1'b0}}, 1'b1};
        end else if (i_accept) begin
            r_next_ordinal <= n_next_ordinal;
        end
    end

`ifndef SYNTHESIS
    a_ord_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_ordinal != '0)
        else $error("next ordinal reached zero");
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_next_ordinal == {{(ORD_W-1){1'b0}}, 1'b1})
        else $error("ordinal not restarted after last word");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_next_ordinal))
        else $error("ordinal moved without an accepted word");
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_last && o_result.status != ST_OK |=> $stable(r_next_ordinal))
        else $error("ordinal moved on an error");
`endif

endmodule

// File: rtl/core/csd_skid.sv
// ---------------------------------------------------------------------------
// csd_skid: two-entry result buffer
// Output register plus a skid register so input keeps flowing on a stall.
// ---------------------------------------------------------------------------
module csd_skid
    import csd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    push;
    logic    out_free;

    assign o_ready  = !r_skid_valid;
    assign push     = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Control: refill the output from skid first, else from the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (push) begin
            r_skid <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while the output is empty");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> r_out_valid && !r_skid_valid)
        else $error("skid word not moved to the output");
    a_skid_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid && $stable(r_skid))
        else $error("skid word lost during a stall");
`endif

endmodule

// File: rtl/core/carrier_sequence_decoder.sv
// ---------------------------------------------------------------------------
// carrier_sequence_decoder: carrier word stream decoder
// Four exponent/slot lanes, a merge with ordinal tracking, a result buffer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one carrier of four binary64
//   words per cycle while o_ready is high. Output channel (o_valid/
//   i_ready) gives one result word per carrier, in order. The config
//   channel (i_cfg_valid/o_cfg_ready) writes the 11-bit carrier
//   exponent; it is always ready and should be written only while no
//   carrier is in flight. Results are registered in the output register
//   or, while the receiver stalls, in the skid word. Throughput: one
//   carrier per cycle while o_ready is high, set by the ordinal loop
//   (one 64-bit add and the ordered checks) in the merge stage. A
//   stalled receiver is absorbed by the output register and one skid
//   word; o_ready drops only when both are full. Reset: exponent to
//   1023, ordinal to 1, result entries emptied; no clearing pass needed.
// ---------------------------------------------------------------------------
module carrier_sequence_decoder
    import csd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [EXP_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [WORD_W-1:0]  i_word_zero,
    input  logic [WORD_W-1:0]  i_word_one,
    input  logic [WORD_W-1:0]  i_word_two,
    input  logic [WORD_W-1:0]  i_word_three,
    input  logic               i_last_in_sequence,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [WORD_W-1:0]  o_id_high_lane,
    output logic [WORD_W-1:0]  o_id_low_lane,
    output logic [ORD_W-1:0]   o_running_ord,
    output logic [SHORT_W-1:0] o_carried_ord,
    output logic [SHORT_W-1:0] o_span_len,
    output logic [META_W-1:0]  o_metadata,
    output logic [ORD_W-1:0]   o_total_count,
    output logic               o_sequence_end
);

    logic [EXP_W-1:0]  r_exponent;
    logic [WORD_W-1:0] words [NUM_LANES];
    t_lane             lanes [NUM_LANES];
    t_result           merged;
    t_result           result;
    logic              accept;

    // Config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_RESET;
        end else if (i_cfg_valid) begin
            r_exponent <= i_cfg_data;
        end
    end

    assign words[0] = i_word_zero;
    assign words[1] = i_word_one;
    assign words[2] = i_word_two;
    assign words[3] = i_word_three;
    assign accept   = i_valid && o_ready;

    // Word lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        csd_lane u_lane (
            .i_word     (words[g]),
            .i_exponent (r_exponent),
            .o_lane     (lanes[g])
        );
    end

    // Merge and ordinal tracking
    csd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lanes  (lanes),
        .i_accept (accept),
        .i_last   (i_last_in_sequence),
        .o_result (merged)
    );

    // Result buffer
    csd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (merged),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (result)
    );

    // Unpack the result word
    assign o_status          = result.status;
    assign o_id_high_lane    = result.id_high_lane;
    assign o_id_low_lane     = result.id_low_lane;
    assign o_running_ord     = result.running_ord;
    assign o_carried_ord     = result.carried_ord;
    assign o_span_len        = result.span_len;
    assign o_metadata        = result.metadata;
    assign o_total_count     = result.total_count;
    assign o_sequence_end    = result.sequence_end;

endmodule
